### sv/sdbb_pkg.sv
// Shared types, constants and tables for the sliding DFT bin bank.
`default_nettype none

package sdbb_pkg;

    localparam int NUM_BINS_DEF  = 16;
    localparam int WINDOW_DEF    = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STEPS  = 16;

    localparam logic signed [42:0] ROT_GAIN = 43'sd652032874;
    localparam logic [15:0]        MAG_GAIN = 16'd39797;
    localparam logic [35:0]        MAX36    = 36'hFFFFFFFFF;

    typedef enum logic [2:0] {
        CFG_WINDOW_LENGTH   = 3'd0,
        CFG_BINS_IN_USE     = 3'd1,
        CFG_CENTER_STEP     = 3'd2,
        CFG_HALF_SPACING    = 3'd3,
        CFG_POWER_THRESHOLD = 3'd4
    } cfg_index_t;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [35:0]        power_sum;
        logic               below_threshold;
        logic [3:0]         strongest_bin;
        logic signed [15:0] strongest_phase;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_PUSH_START,
        OP_DIFF,
        OP_STEP,
        OP_ANGLE,
        OP_ROT_LOAD,
        OP_CORDIC,
        OP_ROT_SAT,
        OP_PROD,
        OP_BIN_ADD,
        OP_PUSH_END,
        OP_QRY_START,
        OP_VEC_LOAD,
        OP_MAG,
        OP_QRY_ACC
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic iter_last;
        logic k_last;
    } dp_status_t;

    // arctan(2^-i) in 2^-32 turns
    function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
        logic signed [33:0] r;
        begin
            r = '0;
            case (i)
                4'd0:  r = 34'sh020000000;
                4'd1:  r = 34'sh012E4051E;
                4'd2:  r = 34'sh009FB385B;
                4'd3:  r = 34'sh0051111D4;
                4'd4:  r = 34'sh0028B0D43;
                4'd5:  r = 34'sh00145D7E1;
                4'd6:  r = 34'sh000A2F61E;
                4'd7:  r = 34'sh000517C55;
                4'd8:  r = 34'sh00028BE53;
                4'd9:  r = 34'sh000145F2F;
                4'd10: r = 34'sh0000A2F98;
                4'd11: r = 34'sh0000517CC;
                4'd12: r = 34'sh000028BE6;
                4'd13: r = 34'sh0000145F3;
                4'd14: r = 34'sh00000A2FA;
                default: r = 34'sh00000517D;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### sv/sdbb_datapath.sv
// Datapath: sample ring, bin sums, shared CORDIC, multipliers and config registers.
`default_nettype none

module sdbb_datapath #(
    parameter int NUM_BINS = sdbb_pkg::NUM_BINS_DEF,
    parameter int WINDOW   = sdbb_pkg::WINDOW_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire sdbb_pkg::dp_cmd_t                cmd,
    output sdbb_pkg::dp_status_t                  status,
    input  wire logic signed [sdbb_pkg::SAMPLE_BITS-1:0] sample,
    input  wire                                   cfg_we,
    input  wire logic [2:0]                       cfg_index,
    input  wire logic [35:0]                      cfg_data,
    output sdbb_pkg::out_item_t                   out_data
);

    localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LW  = $clog2(WINDOW + 1);
    localparam int KW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NBW = $clog2(NUM_BINS + 1);
    localparam int SB  = sdbb_pkg::SAMPLE_BITS;

    // configuration
    logic [8:0]         wlen_reg;
    logic [4:0]         bins_reg;
    logic [31:0]        center_reg;
    logic signed [31:0] hs_reg;
    logic [35:0]        thr_reg;

    // push state
    logic [SB-1:0]      ring [WINDOW];
    logic [SB-1:0]      rd_reg;
    logic [PW-1:0]      clr_reg;
    logic [PW-1:0]      pos_reg;
    logic signed [SB-1:0] smp_reg;
    logic signed [SB:0] d_reg;
    logic [NBW-1:0]     k_reg;
    logic [31:0]        step_reg;
    logic [31:0]        a_reg;
    logic               neg_reg;
    logic               vec_reg;
    logic signed [15:0] c_reg;
    logic signed [15:0] s_reg;
    logic signed [18:0] pr_reg;
    logic signed [18:0] pi_reg;
    logic signed [39:0] bin_re [NUM_BINS];
    logic signed [39:0] bin_im [NUM_BINS];

    // CORDIC
    logic signed [42:0] x_reg;
    logic signed [42:0] y_reg;
    logic signed [33:0] z_reg;
    logic [3:0]         it_reg;

    // query
    logic [41:0]        mag_reg;
    logic [35:0]        sum_reg;
    logic [41:0]        best_reg;
    logic [3:0]         bbin_reg;
    logic [15:0]        bang_reg;
    sdbb_pkg::out_item_t out_reg;

    // effective window and bin count
    logic [LW-1:0]  len;
    logic [NBW-1:0] nb;
    always_comb
    begin
        if (32'(wlen_reg) < 32'd8)
            len = LW'(8);
        else if (32'(wlen_reg) > 32'(WINDOW))
            len = LW'(WINDOW);
        else
            len = LW'(wlen_reg);
        if (bins_reg == 5'd0)
            nb = NBW'(1);
        else if (32'(bins_reg) > 32'(NUM_BINS))
            nb = NBW'(NUM_BINS);
        else
            nb = NBW'(bins_reg);
    end

    logic [PW-1:0] pos_use;
    logic [LW-1:0] pos_inc;
    logic [PW-1:0] pos_nxt;
    assign pos_use = (LW'(pos_reg) >= len) ? '0 : pos_reg;
    assign pos_inc = LW'(pos_reg) + LW'(1);
    assign pos_nxt = (pos_inc >= len) ? '0 : pos_inc[PW-1:0];

    // phase step of bin k: center + (2k - nb) * half_spacing
    logic signed [NBW+1:0]  coef;
    logic signed [NBW+33:0] sp;
    assign coef = $signed({1'b0, k_reg, 1'b0}) - $signed({2'b00, nb});
    assign sp   = (NBW+34)'(coef) * (NBW+34)'(hs_reg);

    logic [PW+31:0] ap;
    assign ap = (PW+32)'(step_reg) * (PW+32)'(pos_reg);

    // rotation preload with quadrant fold
    logic       fold;
    logic [31:0] a_f;
    assign fold = (a_reg[31:30] == 2'b01) || (a_reg[31:30] == 2'b10);
    assign a_f  = fold ? {~a_reg[31], a_reg[30:0]} : a_reg;

    // one CORDIC iteration
    logic signed [42:0] dx;
    logic signed [42:0] dy;
    logic signed [33:0] at;
    logic               dsel;
    assign dx   = y_reg >>> it_reg;
    assign dy   = x_reg >>> it_reg;
    assign at   = sdbb_pkg::atan_turn(it_reg);
    assign dsel = vec_reg ? y_reg[42] : ~z_reg[33];

    // rotation result to Q1.15 with saturation
    function automatic logic signed [15:0] sat_q15(input logic signed [42:0] v,
                                                   input logic neg);
        logic signed [28:0] t;
        begin
            t = 29'($signed(v[42:15]));
            if (neg)
                t = -t;
            if (t > 29'sd32767)
                return 16'sd32767;
            else if (t < -29'sd32768)
                return -16'sd32768;
            else
                return t[15:0];
        end
    endfunction

    logic signed [32:0] p_re;
    logic signed [33:0] p_im;
    assign p_re = 33'(d_reg) * 33'(c_reg);
    assign p_im = -(34'(d_reg) * 34'(s_reg));

    logic [41:0] xc;
    logic [57:0] mprod;
    assign xc    = x_reg[42] ? '0 : x_reg[41:0];
    assign mprod = 58'(xc) * 58'(sdbb_pkg::MAG_GAIN);

    logic [42:0] sum_wide;
    assign sum_wide = 43'(sum_reg) + 43'(mag_reg);

    logic [KW-1:0] ki;
    assign ki = k_reg[KW-1:0];

    // sample ring memory
    logic          ring_we;
    logic [PW-1:0] ring_wa;
    logic [SB-1:0] ring_wd;
    assign ring_we = (cmd.op == sdbb_pkg::OP_CLEAR) || (cmd.op == sdbb_pkg::OP_PUSH_END);
    assign ring_wa = (cmd.op == sdbb_pkg::OP_CLEAR) ? clr_reg : pos_reg;
    assign ring_wd = (cmd.op == sdbb_pkg::OP_CLEAR) ? '0 : smp_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[ring_wa] <= ring_wd;
        if (cmd.op == sdbb_pkg::OP_PUSH_START)
            rd_reg <= ring[pos_use];
    end

    // control-like state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg   <= 9'd256;
            bins_reg   <= 5'd16;
            center_reg <= 32'd128849019;
            hs_reg     <= 32'sd4295;
            thr_reg    <= 36'd4000;
            clr_reg    <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            it_reg     <= '0;
            vec_reg    <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_re[i] <= '0;
                bin_im[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sdbb_pkg::CFG_WINDOW_LENGTH:   wlen_reg   <= cfg_data[8:0];
                    sdbb_pkg::CFG_BINS_IN_USE:     bins_reg   <= cfg_data[4:0];
                    sdbb_pkg::CFG_CENTER_STEP:     center_reg <= cfg_data[31:0];
                    sdbb_pkg::CFG_HALF_SPACING:    hs_reg     <= $signed(cfg_data[31:0]);
                    sdbb_pkg::CFG_POWER_THRESHOLD: thr_reg    <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                sdbb_pkg::OP_CLEAR:
                    clr_reg <= (clr_reg == PW'(WINDOW - 1)) ? '0 : clr_reg + PW'(1);
                sdbb_pkg::OP_PUSH_START:
                begin
                    pos_reg <= pos_use;
                    k_reg   <= '0;
                end
                sdbb_pkg::OP_QRY_START:
                    k_reg <= '0;
                sdbb_pkg::OP_ROT_LOAD:
                begin
                    it_reg  <= '0;
                    vec_reg <= 1'b0;
                end
                sdbb_pkg::OP_VEC_LOAD:
                begin
                    it_reg  <= '0;
                    vec_reg <= 1'b1;
                end
                sdbb_pkg::OP_CORDIC:
                    it_reg <= it_reg + 4'd1;
                sdbb_pkg::OP_BIN_ADD:
                begin
                    bin_re[ki] <= bin_re[ki] + 40'(pr_reg);
                    bin_im[ki] <= bin_im[ki] + 40'(pi_reg);
                    k_reg      <= k_reg + NBW'(1);
                end
                sdbb_pkg::OP_PUSH_END:
                    pos_reg <= pos_nxt;
                sdbb_pkg::OP_QRY_ACC:
                    k_reg <= k_reg + NBW'(1);
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sdbb_pkg::OP_PUSH_START:
                smp_reg <= sample;
            sdbb_pkg::OP_DIFF:
                d_reg <= (SB+1)'(smp_reg) - (SB+1)'($signed(rd_reg));
            sdbb_pkg::OP_STEP:
                step_reg <= center_reg + sp[31:0];
            sdbb_pkg::OP_ANGLE:
                a_reg <= ap[31:0];
            sdbb_pkg::OP_ROT_LOAD:
            begin
                x_reg   <= sdbb_pkg::ROT_GAIN;
                y_reg   <= '0;
                z_reg   <= 34'($signed(a_f));
                neg_reg <= fold;
            end
            sdbb_pkg::OP_VEC_LOAD:
            begin
                if (bin_re[ki][39])
                begin
                    x_reg <= -43'(bin_re[ki]);
                    y_reg <= -43'(bin_im[ki]);
                    z_reg <= 34'sh080000000;
                end
                else
                begin
                    x_reg <= 43'(bin_re[ki]);
                    y_reg <= 43'(bin_im[ki]);
                    z_reg <= '0;
                end
            end
            sdbb_pkg::OP_CORDIC:
            begin
                if (dsel)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
            end
            sdbb_pkg::OP_ROT_SAT:
            begin
                c_reg <= sat_q15(x_reg, neg_reg);
                s_reg <= sat_q15(y_reg, neg_reg);
            end
            sdbb_pkg::OP_PROD:
            begin
                pr_reg <= 19'(p_re >>> 15);
                pi_reg <= 19'(p_im >>> 15);
            end
            sdbb_pkg::OP_QRY_START:
            begin
                sum_reg  <= '0;
                best_reg <= '0;
                bbin_reg <= '0;
                bang_reg <= '0;
            end
            sdbb_pkg::OP_MAG:
                mag_reg <= mprod[57:16];
            sdbb_pkg::OP_QRY_ACC:
            begin
                sum_reg <= (sum_wide > 43'(sdbb_pkg::MAX36)) ? sdbb_pkg::MAX36
                                                             : sum_wide[35:0];
                if (best_reg < mag_reg)
                begin
                    best_reg <= mag_reg;
                    bbin_reg <= 4'(k_reg);
                    bang_reg <= z_reg[31:16];
                end
            end
            default: ;
        endcase
        if (cmd.out_load)
        begin
            out_reg.power_sum       <= sum_reg;
            out_reg.below_threshold <= (sum_reg < thr_reg);
            out_reg.strongest_bin   <= bbin_reg;
            out_reg.strongest_phase <= $signed(bang_reg);
        end
    end

    assign status.clear_last = (clr_reg == PW'(WINDOW - 1));
    assign status.iter_last  = (it_reg == 4'(sdbb_pkg::CORDIC_STEPS - 1));
    assign status.k_last     = (k_reg == nb - NBW'(1));
    assign out_data          = out_reg;

endmodule

`default_nettype wire

### sv/sdbb_ctrl.sv
// Controller: sequences clearing, bin updates and queries over the shared datapath.
`default_nettype none

module sdbb_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  wire                  in_mode,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire                  out_stall,
    input  wire sdbb_pkg::dp_status_t status,
    output sdbb_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIFF,
        S_STEP,
        S_ANGLE,
        S_ROT_LOAD,
        S_ROT_RUN,
        S_ROT_SAT,
        S_PROD,
        S_BIN_ADD,
        S_PUSH_END,
        S_VEC_LOAD,
        S_VEC_RUN,
        S_MAG,
        S_QACC,
        S_QEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   take;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign take      = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = sdbb_pkg::OP_NONE;
        cmd.out_load   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = sdbb_pkg::OP_CLEAR;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (take)
                begin
                    if (in_mode == sdbb_pkg::MODE_QUERY)
                    begin
                        cmd.op     = sdbb_pkg::OP_QRY_START;
                        state_next = S_VEC_LOAD;
                    end
                    else
                    begin
                        cmd.op     = sdbb_pkg::OP_PUSH_START;
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                cmd.op     = sdbb_pkg::OP_DIFF;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.op     = sdbb_pkg::OP_STEP;
                state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                cmd.op     = sdbb_pkg::OP_ANGLE;
                state_next = S_ROT_LOAD;
            end
            S_ROT_LOAD:
            begin
                cmd.op     = sdbb_pkg::OP_ROT_LOAD;
                state_next = S_ROT_RUN;
            end
            S_ROT_RUN:
            begin
                cmd.op = sdbb_pkg::OP_CORDIC;
                if (status.iter_last)
                    state_next = S_ROT_SAT;
            end
            S_ROT_SAT:
            begin
                cmd.op     = sdbb_pkg::OP_ROT_SAT;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.op     = sdbb_pkg::OP_PROD;
                state_next = S_BIN_ADD;
            end
            S_BIN_ADD:
            begin
                cmd.op     = sdbb_pkg::OP_BIN_ADD;
                state_next = status.k_last ? S_PUSH_END : S_STEP;
            end
            S_PUSH_END:
            begin
                cmd.op     = sdbb_pkg::OP_PUSH_END;
                state_next = S_IDLE;
            end
            S_VEC_LOAD:
            begin
                cmd.op     = sdbb_pkg::OP_VEC_LOAD;
                state_next = S_VEC_RUN;
            end
            S_VEC_RUN:
            begin
                cmd.op = sdbb_pkg::OP_CORDIC;
                if (status.iter_last)
                    state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.op     = sdbb_pkg::OP_MAG;
                state_next = S_QACC;
            end
            S_QACC:
            begin
                cmd.op     = sdbb_pkg::OP_QRY_ACC;
                state_next = status.k_last ? S_QEND : S_VEC_LOAD;
            end
            S_QEND:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/sliding_dft_bin_bank_unit.sv
// Top level of the sliding DFT bin bank: controller, datapath and config port.
//
//  channel   signals                               transfer when
//  in        in_valid, in_stall, in_data           in_valid && !in_stall
//  out       out_valid, out_stall, out_data        out_valid && !out_stall
//  cfg       cfg_valid, cfg_ready, cfg_index/data  cfg_valid && cfg_ready
//
// A push updates each bin in use in turn; a query reads each in turn, plus any
// wait on the output register. The 16-iteration shared CORDIC sets the per-bin cost.
// After reset a clearing pass over all WINDOW entries zeroes the sample ring; in_stall
// is high during it. A query result waits in the output register while out_stall
// is high, and the next item can be taken meanwhile.
`default_nettype none

module sliding_dft_bin_bank_unit #(
    parameter int NUM_BINS = sdbb_pkg::NUM_BINS_DEF,
    parameter int WINDOW   = sdbb_pkg::WINDOW_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire sdbb_pkg::in_item_t in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output sdbb_pkg::out_item_t out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [35:0]    cfg_data
);

    sdbb_pkg::dp_cmd_t    cmd;
    sdbb_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sdbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (in_data.mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sdbb_datapath #(
        .NUM_BINS (NUM_BINS),
        .WINDOW   (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (in_data.sample),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

`ifndef SYNTH
    a_start_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |->
            (cmd.op == sdbb_pkg::OP_PUSH_START || cmd.op == sdbb_pkg::OP_QRY_START))
        else $error("accepted item did not start a sequence");

    a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sdbb_pkg::OP_PUSH_START |=> in_stall)
        else $error("input taken while a push is in progress");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result loaded without out_valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
